// ===== sv/ihex_pkg.sv =====
// Shared types, codes and per-character decode functions of the Intel HEX record decoder.
`timescale 1ns / 1ps

package ihex_pkg;

    // Character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Record geometry
    localparam logic [9:0] MIN_LEN = 10'd11;
    localparam logic [9:0] POS_MAX = 10'd1023;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_BAD_SUM   = 3'd3;
    localparam logic [2:0] ST_BAD_DIGIT = 3'd4;

    // Per-record decode state
    typedef struct packed {
        logic [9:0]  pos;
        logic [3:0]  hi;
        logic [7:0]  cnt;
        logic [15:0] addr;
        logic [7:0]  typ;
        logic [7:0]  sum;
        logic        derr;
        logic        serr;
    } t_rec;

    // State after one character plus a possible data byte
    typedef struct packed {
        t_rec       st;
        logic       have;
        logic [7:0] val;
        logic [7:0] idx;
    } t_feed;

    // {valid, nibble} of an ASCII hex digit; non-hex gives value 0
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    // Advance the record state by one character
    function automatic t_feed feed_char(input t_rec s, input logic [7:0] c);
        t_feed      f;
        logic [4:0] h;
        logic [7:0] b;
        logic [8:0] k;
        logic [8:0] di;
        f.st   = s;
        f.have = 1'b0;
        f.val  = 8'd0;
        f.idx  = 8'd0;
        h      = hex_digit(c);
        b      = {s.hi, h[3:0]};
        k      = s.pos[9:1] - 9'd1;
        di     = k - 9'd4;
        if (s.pos != POS_MAX) begin
            f.st.pos = s.pos + 10'd1;
            if (s.pos == 10'd0) begin
                if (c != CH_COLON) begin
                    f.st.serr = 1'b1;
                end
            end else begin
                if (!h[4]) begin
                    f.st.derr = 1'b1;
                end
                if (s.pos[0]) begin
                    f.st.hi = h[3:0];
                end else begin
                    f.st.sum = s.sum + b;
                    if (k == 9'd0) begin
                        f.st.cnt = b;
                    end else if (k == 9'd1) begin
                        f.st.addr[15:8] = b;
                    end else if (k == 9'd2) begin
                        f.st.addr[7:0] = b;
                    end else if (k == 9'd3) begin
                        f.st.typ = b;
                    end else if (di < {1'b0, s.cnt}) begin
                        f.have = 1'b1;
                        f.val  = b;
                        f.idx  = di[7:0];
                    end
                end
            end
        end
        return f;
    endfunction

    // End-of-record verdict, in priority order
    function automatic logic [2:0] rec_status(input t_rec s);
        logic [2:0] st;
        if (s.serr || s.pos < MIN_LEN) begin
            st = ST_BAD_START;
        end else if (s.pos != MIN_LEN + {1'b0, s.cnt, 1'b0}) begin
            st = ST_BAD_LEN;
        end else if (s.derr) begin
            st = ST_BAD_DIGIT;
        end else if (s.sum != 8'd0) begin
            st = ST_BAD_SUM;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

endpackage

// ===== sv/ihex_in_if.sv =====
// Character input channel: valid/ready with one character per beat.
`timescale 1ns / 1ps

interface ihex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       final_char;

    modport source (output valid, output char_in, output final_char, input ready);
    modport sink   (input valid, input char_in, input final_char, output ready);
endinterface

// ===== sv/ihex_out_if.sv =====
// Result channel: valid/ready with one data byte or record status per beat.
`timescale 1ns / 1ps

interface ihex_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [15:0] record_address;
    logic [7:0]  record_type;
    logic [7:0]  byte_count;
    logic [2:0]  status;

    modport source (output valid, output kind, output data_byte, output data_index,
                    output record_address, output record_type, output byte_count,
                    output status, input ready);
    modport sink   (input valid, input kind, input data_byte, input data_index,
                    input record_address, input record_type, input byte_count,
                    input status, output ready);
endinterface

// ===== sv/intel_hex_record_decoder.sv =====
// Top level: streaming Intel HEX record decoder.
// Usage:
//   i_in takes one ASCII character per beat; final_char marks the last
//   character of the stream and closes the record in progress.
//   o_out gives one beat per decoded data byte (kind 0) and one status beat
//   (kind 1) at the end of every non-empty record. A record ends at CR LF.
//   Downstream drops the data bytes of a record whose status is not ok.
// Output: a result is registered and appears on o_out in the cycle after
//   the character that causes it is accepted.
// Throughput: one character per cycle when not stalled; all decode work for
//   a character is one pass of combinational logic into the result register.
// Stall: i_in.ready is high while the result register is empty or being
//   taken in the same cycle; a held result blocks new characters.
// Reset: synchronous, active low; clears the record state, the pending CR
//   flag and the result valid. No clearing pass is needed.
`timescale 1ns / 1ps

module intel_hex_record_decoder
    import ihex_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ihex_in_if.sink     i_in,
    ihex_out_if.source  o_out
);

    t_rec        r_rec, n_rec;
    logic        r_pend, n_pend;
    logic        r_out_valid;
    logic        n_res;
    logic        r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic [7:0]  r_index, n_index;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_count, n_count;
    logic [2:0]  r_status, n_status;

    t_rec  s_clear;
    t_feed f_cr, f_ch;
    t_rec  s_mid, s_end;
    logic  acc;

    assign acc        = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign s_clear    = '0;

    // Two feeds: a held CR that turned out not to start CR LF, then this char
    assign f_cr  = feed_char(r_rec, CH_CR);
    assign s_mid = r_pend ? f_cr.st : r_rec;
    assign f_ch  = feed_char(s_mid, i_in.char_in);

    // Next record state and result
    always_comb begin
        n_rec    = r_rec;
        n_pend   = r_pend;
        n_res    = 1'b0;
        n_kind   = KIND_DATA;
        n_byte   = 8'd0;
        n_index  = 8'd0;
        n_addr   = r_rec.addr;
        n_type   = r_rec.typ;
        n_count  = r_rec.cnt;
        n_status = ST_OK;
        s_end    = s_mid;
        if (r_pend && i_in.char_in == CH_LF) begin
            // CR LF closes the record
            n_pend   = 1'b0;
            n_res    = (r_rec.pos != 10'd0);
            n_kind   = KIND_STATUS;
            n_status = rec_status(r_rec);
            n_rec    = s_clear;
        end else begin
            if (i_in.char_in == CH_CR && !i_in.final_char) begin
                n_pend = 1'b1;
                s_end  = s_mid;
            end else begin
                n_pend = 1'b0;
                s_end  = f_ch.st;
            end
            n_addr  = s_end.addr;
            n_type  = s_end.typ;
            n_count = s_end.cnt;
            if (i_in.final_char) begin
                n_pend   = 1'b0;
                n_res    = (s_end.pos != 10'd0);
                n_kind   = KIND_STATUS;
                n_status = rec_status(s_end);
                n_rec    = s_clear;
            end else begin
                n_rec = s_end;
                if (r_pend && f_cr.have) begin
                    n_res   = 1'b1;
                    n_byte  = f_cr.val;
                    n_index = f_cr.idx;
                end
                if (!(i_in.char_in == CH_CR) && f_ch.have) begin
                    n_res   = 1'b1;
                    n_byte  = f_ch.val;
                    n_index = f_ch.idx;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_rec  <= n_rec;
                r_pend <= n_pend;
            end
            if (acc) begin
                r_out_valid <= n_res;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (acc && n_res) begin
            r_kind   <= n_kind;
            r_byte   <= n_byte;
            r_index  <= n_index;
            r_addr   <= n_addr;
            r_type   <= n_type;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_kind;
    assign o_out.data_byte      = r_byte;
    assign o_out.data_index     = r_index;
    assign o_out.record_address = r_addr;
    assign o_out.record_type    = r_type;
    assign o_out.byte_count     = r_count;
    assign o_out.status         = r_status;

endmodule

// ===== dv/tb_intel_hex_record_decoder.sv =====
// Testbench for the Intel HEX record decoder: random record streams, in-order result check.
`timescale 1ns / 1ps

module tb_intel_hex_record_decoder;
    import ihex_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_CHARS = 220;
    localparam int LIMIT_CYCLES = 150000;
    localparam int HOLD_AT      = 400;   // receiver hold-off start, in monitor cycles
    localparam int HOLD_LEN     = 300;
    localparam int CALM_FROM    = 1000;  // window with no idling on either side
    localparam int CALM_TO      = 1300;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        FLAW_NONE, FLAW_SUM, FLAW_DIGIT, FLAW_LENGTH, FLAW_START, FLAW_SHORT, FLAW_LONE_CR
    } t_rec_flaw;

    typedef enum int { END_CRLF, END_FINAL, END_CR_FINAL } t_rec_end;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       drain_first;  // hold this beat until all results are back
    } t_char_beat;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [15:0] record_address;
        logic [7:0]  record_type;
        logic [7:0]  byte_count;
        logic [2:0]  status;
    } t_hex_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ihex_in_if  in_bus ();
    ihex_out_if out_bus ();

    intel_hex_record_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_char_beat  char_q[$];
    t_hex_result expected_results[$];
    int          fail_count = 0;
    logic        drain_next = 1'b0;

    // Decoder mirror: record state
    logic [9:0]  rec_len       = '0;
    logic [3:0]  hi_digit      = '0;
    logic [7:0]  hdr_count     = '0;
    logic [15:0] hdr_addr      = '0;
    logic [7:0]  hdr_type      = '0;
    logic [7:0]  chk_sum       = '0;
    logic        cr_waiting    = 1'b0;
    logic        saw_bad_digit = 1'b0;
    logic        saw_bad_colon = 1'b0;
    logic        byte_ready    = 1'b0;
    logic [7:0]  byte_val      = '0;
    logic [7:0]  byte_pos      = '0;

    // ASCII hex digit to nibble; returns 0 for anything else
    function automatic logic decode_hex(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
            return 1'b1;
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_result(input logic kind, input logic [7:0] val,
                                        input logic [7:0] idx, input logic [2:0] st);
        t_hex_result r;
        r.kind           = kind;
        r.data_byte      = val;
        r.data_index     = idx;
        r.record_address = hdr_addr;
        r.record_type    = hdr_type;
        r.byte_count     = hdr_count;
        r.status         = st;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // One record character into the mirror state
    function automatic void take_char(input logic [7:0] c);
        logic [9:0] p;
        logic [3:0] v;
        logic [7:0] b;
        logic       ok;
        int         k;
        p = rec_len;
        if (p == POS_MAX) return;
        rec_len = p + 10'd1;
        if (p == 10'd0) begin
            if (c != CH_COLON) saw_bad_colon = 1'b1;
            return;
        end
        ok = decode_hex(c, v);
        if (!ok) saw_bad_digit = 1'b1;
        if (p[0]) begin
            hi_digit = v;
            return;
        end
        b       = {hi_digit, v};
        k       = (int'(p) - 2) / 2;
        chk_sum = chk_sum + b;
        case (k)
            0: hdr_count = b;
            1: hdr_addr[15:8] = b;
            2: hdr_addr[7:0] = b;
            3: hdr_type = b;
            default: begin
                if (k - 4 < int'(hdr_count)) begin
                    byte_ready = 1'b1;
                    byte_val   = b;
                    byte_pos   = 8'(k - 4);
                end
            end
        endcase
    endfunction

    // Verdict in priority order: start/short, length, digit, checksum
    function automatic logic [2:0] record_verdict();
        if (saw_bad_colon || rec_len < MIN_LEN) return ST_BAD_START;
        if (int'(rec_len) != int'(MIN_LEN) + 2 * int'(hdr_count)) return ST_BAD_LEN;
        if (saw_bad_digit) return ST_BAD_DIGIT;
        if (chk_sum != 8'd0) return ST_BAD_SUM;
        return ST_OK;
    endfunction

    function automatic void close_record();
        if (rec_len != 10'd0) push_result(KIND_STATUS, 8'd0, 8'd0, record_verdict());
        rec_len       = '0;
        hi_digit      = '0;
        hdr_count     = '0;
        hdr_addr      = '0;
        hdr_type      = '0;
        chk_sum       = '0;
        saw_bad_digit = 1'b0;
        saw_bad_colon = 1'b0;
    endfunction

    // Accepted beat: CR LF splitting, then expected results
    function automatic void decode_beat(input logic [7:0] c, input logic fin);
        byte_ready = 1'b0;
        if (cr_waiting) begin
            cr_waiting = 1'b0;
            if (c == CH_LF) begin
                close_record();
                return;
            end
            take_char(CH_CR);
        end
        if (c == CH_CR && !fin) cr_waiting = 1'b1;
        else take_char(c);
        if (fin) begin
            cr_waiting = 1'b0;
            close_record();
            return;
        end
        if (byte_ready) push_result(KIND_DATA, byte_val, byte_pos, ST_OK);
    endfunction

    // Stimulus helpers
    function automatic void put_char(input logic [7:0] c, input logic fin);
        t_char_beat b;
        b.ch          = c;
        b.fin         = fin;
        b.drain_first = drain_next;
        drain_next    = 1'b0;
        char_q.insert(char_q.size(), b);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i], 1'b0);
    endfunction

    function automatic void eol();
        put_char(CH_CR, 1'b0);
        put_char(CH_LF, 1'b0);
    endfunction

    // Random letter case for A-F
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        if ($urandom_range(0, 1) != 0) return 8'h37 + n;
        return 8'h57 + n;
    endfunction

    // Random record of n data bytes with a correct checksum, then at most one flaw
    function automatic void put_record(input int n, input t_rec_flaw flaw, input t_rec_end ending);
        logic [7:0] bytes[$];
        logic [7:0] txt[$];
        logic [7:0] sum;
        logic [7:0] c;
        logic [3:0] v;
        int         skip_at;
        int         extra_at;
        int         cr_at;
        int         n_emit;
        skip_at  = -1;
        extra_at = -1;
        cr_at    = -1;
        sum      = 8'd0;
        bytes.insert(bytes.size(), 8'(n));
        bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
        bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 80) bytes.insert(bytes.size(), 8'($urandom_range(0, 5)));
        else bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
        for (int i = 0; i < n; i++) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
        for (int i = 0; i < bytes.size(); i++) sum = sum + bytes[i];
        bytes.insert(bytes.size(), 8'd0 - sum);
        if (flaw == FLAW_SUM) bytes[bytes.size() - 1] ^= 8'($urandom_range(1, 255));

        txt.insert(txt.size(), CH_COLON);
        for (int i = 0; i < bytes.size(); i++) begin
            txt.insert(txt.size(), hex_char(bytes[i][7:4]));
            txt.insert(txt.size(), hex_char(bytes[i][3:0]));
        end
        n_emit = txt.size();

        case (flaw)
            FLAW_DIGIT: begin
                do c = 8'($urandom_range(0, 255)); while (decode_hex(c, v));
                txt[$urandom_range(1, txt.size() - 1)] = c;
            end
            FLAW_LENGTH: begin
                if ($urandom_range(0, 1) != 0) skip_at = $urandom_range(1, txt.size() - 1);
                else extra_at = $urandom_range(1, txt.size() - 1);
            end
            FLAW_START: begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_COLON);
                txt[0] = c;
            end
            FLAW_SHORT: n_emit = $urandom_range(1, 10);
            FLAW_LONE_CR: cr_at = $urandom_range(1, txt.size());
            default: ;
        endcase

        for (int i = 0; i < n_emit; i++) begin
            if (i == extra_at) put_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
            if (i == cr_at) put_char(CH_CR, 1'b0);
            if (i != skip_at) put_char(txt[i], 1'b0);
        end
        if (cr_at == n_emit) put_char(CH_CR, 1'b0);

        case (ending)
            END_CRLF: eol();
            END_FINAL: char_q[char_q.size() - 1].fin = 1'b1;
            default: put_char(CH_CR, 1'b1);
        endcase
    endfunction

    // Compare one result field; X counts as a mismatch
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Character driver
    int drv_cycles = 0;

    always @(posedge i_clk) begin : char_driver
        if (!i_rst_n) begin
            in_bus.valid      <= 1'b0;
            in_bus.char_in    <= 8'd0;
            in_bus.final_char <= 1'b0;
        end else begin
            drv_cycles++;
            if (in_bus.valid && in_bus.ready) begin
                decode_beat(in_bus.char_in, in_bus.final_char);
                void'(char_q.pop_front());
            end
            // a beat still waiting for ready stays on the bus
            if (!(in_bus.valid && !in_bus.ready)) begin
                if (char_q.size() != 0
                        && !(char_q[0].drain_first && expected_results.size() != 0)
                        && !($urandom_range(0, 99) < 10
                             && !(drv_cycles >= CALM_FROM && drv_cycles < CALM_TO))) begin
                    in_bus.valid      <= 1'b1;
                    in_bus.char_in    <= char_q[0].ch;
                    in_bus.final_char <= char_q[0].fin;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random stalls and one long hold-off
    int mon_cycles = 0;
    int hold_left  = 0;

    always @(posedge i_clk) begin : result_monitor
        t_hex_result want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            mon_cycles++;
            if (out_bus.valid && out_bus.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got kind %0h status %0h",
                             $time, out_bus.kind, out_bus.status);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(out_bus.kind));
                    check_field("data_byte", 32'(want.data_byte), 32'(out_bus.data_byte));
                    check_field("data_index", 32'(want.data_index), 32'(out_bus.data_index));
                    check_field("record_address", 32'(want.record_address),
                                32'(out_bus.record_address));
                    check_field("record_type", 32'(want.record_type),
                                32'(out_bus.record_type));
                    check_field("byte_count", 32'(want.byte_count), 32'(out_bus.byte_count));
                    check_field("status", 32'(want.status), 32'(out_bus.status));
                end
            end
            if (mon_cycles == HOLD_AT) hold_left = HOLD_LEN;
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= (mon_cycles >= CALM_FROM && mon_cycles < CALM_TO)
                                 || $urandom_range(0, 99) >= 10;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int        start_len;
        int        n;
        int        r;
        logic      mid_done;
        t_rec_flaw flaw;
        t_rec_end  ending;
        mid_done = 1'b0;

        // directed records
        put_text(":00000001FF"); eol();                      // good end-of-file record
        eol(); eol();                                         // empty records
        put_char(8'hFF, 1'b0); put_text("00000001FF"); eol(); // bad start
        put_text(":00"); put_char(8'h00, 1'b0); eol();        // too short
        put_text(":01FFFF00FF02"); eol();                     // good, all-ones address and data
        put_text(":0200000000AB"); eol();                     // length mismatch
        put_text(":00G00001FF"); eol();                       // non-hex digit
        put_text(":00000001FE"); eol();                       // checksum error
        put_text(":00"); put_char(CH_CR, 1'b0); put_text("000001FF"); eol(); // lone CR
        put_text(":03000000A"); put_char(8'h42, 1'b1);        // data byte on the final beat
        put_text(":00000001FF"); put_char(CH_CR, 1'b1);       // CR as final character
        put_text(":00000001FF"); put_char(CH_CR, 1'b0); put_char(CH_LF, 1'b1);
        put_text(":00"); put_char(CH_CR, 1'b0); eol();        // CR CR LF
        put_text(":FF");                                      // largest count, then
        for (int i = 0; i < 1028; i++)                        // past the position limit
            put_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
        eol();

        // random part: mostly records, some noise and empty lines
        drain_next = 1'b1;
        start_len  = char_q.size();
        while (char_q.size() - start_len < RANDOM_CHARS) begin
            if (!mid_done && char_q.size() - start_len >= RANDOM_CHARS / 2) begin
                drain_next = 1'b1;
                mid_done   = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 75) begin
                n = ($urandom_range(0, 99) < 97) ? $urandom_range(0, 12) : $urandom_range(13, 48);
                flaw = ($urandom_range(0, 99) < 60) ? FLAW_NONE
                                                    : t_rec_flaw'($urandom_range(1, 6));
                r = $urandom_range(0, 99);
                ending = (r < 85) ? END_CRLF : (r < 95) ? END_FINAL : END_CR_FINAL;
                put_record(n, flaw, ending);
            end else if (r < 92) begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    put_char(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
                eol();
            end else begin
                eol();
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_q.size() != 0) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== intel_hex_record_decoder.f =====
sv/ihex_pkg.sv
sv/ihex_in_if.sv
sv/ihex_out_if.sv
sv/intel_hex_record_decoder.sv
dv/tb_intel_hex_record_decoder.sv
